// File: hw/rtl/wssd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and sample conversion functions for the wav stream decoder
// no dependencies
package wssd_pkg;

  localparam int COUNT_BITS = 32;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_LIMIT = FIFO_DEPTH - 4;
  localparam logic [5:0] MIN_FILE_BYTES = 6'd44;

  localparam logic [31:0] TAG_RIFF_BE = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE_BE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT_LE  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA_LE = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  localparam logic RK_FRAME  = 1'b0;
  localparam logic RK_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_NO_DATA   = 3'd3,
    ST_UNSUPP    = 3'd4,
    ST_MALFORMED = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    MODE_U8,
    MODE_S16,
    MODE_S24,
    MODE_RAW32,
    MODE_F64
  } mode_t;

  typedef enum logic [1:0] {
    CH_LEFT,
    CH_RIGHT,
    CH_OTHER
  } chan_t;

  // one parsed byte worth of work, handed from the parser to the converter
  typedef struct packed {
    logic                  samp_valid;
    logic [63:0]           raw;
    mode_t                 mode;
    chan_t                 chan;
    logic                  frame_end;
    logic                  mono;
    logic                  report_valid;
    status_t               status;
    logic [31:0]           rate;
    logic [15:0]           channels;
    logic [COUNT_BITS-1:0] frames;
  } samp_evt_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
    status_t     status;
    logic [31:0] rate;
    logic [15:0] channels;
    logic [31:0] frames;
  } result_t;

  // signed integer v scaled by 2^-frac, exact in single precision
  function automatic logic [31:0] pcm_to_single(input logic [23:0] v, input logic [4:0] frac);
    logic        sgn;
    logic [23:0] mag;
    logic [4:0]  p;
    logic [23:0] norm;
    logic [7:0]  ex;
    sgn = v[23];
    mag = sgn ? (~v + 24'd1) : v;
    p = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (mag[i]) p = 5'(i);
    end
    norm = mag << (5'd23 - p);
    ex = 8'd127 + {3'b000, p} - {3'b000, frac};
    if (mag == 24'd0) return 32'd0;
    return {sgn, ex, norm[22:0]};
  endfunction

  // double to single, round to nearest even, subnormals kept, quiet nan
  function automatic logic [31:0] double_to_single(input logic [63:0] d);
    logic               sgn;
    logic [10:0]        exv;
    logic [51:0]        man;
    logic [52:0]        m;
    logic signed [12:0] fe;
    logic [5:0]         shift;
    logic [31:0]        base;
    logic [63:0]        mx;
    logic [63:0]        q;
    logic [63:0]        low_mask;
    logic               rb;
    logic               sticky;
    sgn = d[63];
    exv = d[62:52];
    man = d[51:0];
    m = (exv != 11'd0) ? {1'b1, man} : {1'b0, man};
    fe = $signed({2'b00, ((exv != 11'd0) ? exv : 11'd1)}) - 13'sd896;
    if (fe <= 13'sd0) begin
      shift = 6'(13'sd30 - fe);
      base = 32'd0;
    end else begin
      shift = 6'd29;
      base = {fe[8:0] - 9'd1, 23'd0};
    end
    mx = {11'd0, m};
    q = mx >> shift;
    low_mask = (64'd1 << (shift - 6'd1)) - 64'd1;
    rb = mx[shift - 6'd1];
    sticky = |(mx & low_mask);
    if (rb && (sticky || q[0])) q = q + 64'd1;
    if (exv == 11'h7FF) begin
      if (man == 52'd0) return {sgn, 31'h7F80_0000};
      return {sgn, 31'h7FC0_0000} | {9'd0, man[51:29]};
    end
    if (fe >= 13'sd255) return {sgn, 31'h7F80_0000};
    if (fe < -13'sd33) return {sgn, 31'd0};
    return {sgn, 31'd0} | (base + q[31:0]);
  endfunction

endpackage

// File: hw/rtl/wssd_parser.sv
`timescale 1ns / 1ps
// riff/wave byte parser: tag checks, chunk walk, fmt latch, sample gather, eof report
// depends on wssd_pkg
module wssd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic [7:0]         file_byte,
  input  logic               end_of_file,
  output wssd_pkg::samp_evt_t evt
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  phase_t                          phase, phase_next;
  logic [5:0]                      pos, pos_next;
  logic [63:0]                     win, win_next;
  logic [32:0]                     skip, skip_next;
  logic [31:0]                     dleft, dleft_next;
  logic [15:0]                     fmt_code, fmt_code_next;
  logic [15:0]                     chans, chans_next;
  logic [31:0]                     rate, rate_next;
  logic [15:0]                     bits, bits_next;
  logic                            fmt_seen, fmt_seen_next;
  logic [63:0]                     gather, gather_next;
  logic [3:0]                      bis, bis_next;
  logic [15:0]                     ci, ci_next;
  logic [wssd_pkg::COUNT_BITS-1:0] frames, frames_next;
  wssd_pkg::status_t               err, err_next;
  wssd_pkg::samp_evt_t             evt_next;

  logic [63:0] win_tmp;
  logic [63:0] gath_tmp;
  logic [31:0] csize;
  logic [3:0]  bis_inc;
  logic [16:0] ci_inc;
  wssd_pkg::status_t chk;

  function automatic wssd_pkg::status_t check_format(input logic [15:0] f,
                                                     input logic [15:0] c,
                                                     input logic [15:0] b);
    if (f != wssd_pkg::FMT_PCM && f != wssd_pkg::FMT_FLOAT) return wssd_pkg::ST_UNSUPP;
    if (c == 16'd0 || b < 16'd8) return wssd_pkg::ST_MALFORMED;
    if (f == wssd_pkg::FMT_PCM && b != 16'd8 && b != 16'd16 && b != 16'd24 && b != 16'd32)
      return wssd_pkg::ST_UNSUPP;
    if (f == wssd_pkg::FMT_FLOAT && b != 16'd32 && b != 16'd64) return wssd_pkg::ST_UNSUPP;
    return wssd_pkg::ST_OK;
  endfunction

  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    win_next      = win;
    skip_next     = skip;
    dleft_next    = dleft;
    fmt_code_next = fmt_code;
    chans_next    = chans;
    rate_next     = rate;
    bits_next     = bits;
    fmt_seen_next = fmt_seen;
    gather_next   = gather;
    bis_next      = bis;
    ci_next       = ci;
    frames_next   = frames;
    err_next      = err;
    evt_next      = '0;
    win_tmp       = win;
    gath_tmp      = gather;
    for (int i = 0; i < 8; i++) begin
      if (bis[2:0] == 3'(i)) begin
        win_tmp[i*8 +: 8]  = file_byte;
        gath_tmp[i*8 +: 8] = file_byte;
      end
    end
    csize   = win_tmp[63:32];
    bis_inc = bis + 4'd1;
    ci_inc  = {1'b0, ci} + 17'd1;
    chk     = check_format(fmt_code, chans, bits);

    if (acc) begin
      if (pos < wssd_pkg::MIN_FILE_BYTES) pos_next = pos + 6'd1;
      unique case (phase)
        PH_HEADER: begin
          win_next = {win[55:0], file_byte};
          if (pos == 6'd3 && win_next[31:0] != wssd_pkg::TAG_RIFF_BE) begin
            err_next   = wssd_pkg::ST_BAD_HDR;
            phase_next = PH_DONE;
          end else if (pos == 6'd11) begin
            if (win_next[31:0] != wssd_pkg::TAG_WAVE_BE) begin
              err_next   = wssd_pkg::ST_BAD_HDR;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_CHUNK;
              bis_next   = 4'd0;
              win_next   = 64'd0;
            end
          end
        end
        PH_CHUNK: begin
          win_next = win_tmp;
          bis_next = bis_inc;
          if (bis_inc >= 4'd8) begin
            bis_next = 4'd0;
            if (win_tmp[31:0] == wssd_pkg::TAG_FMT_LE) begin
              if (csize < 32'd16) begin
                err_next   = wssd_pkg::ST_MALFORMED;
                phase_next = PH_DONE;
              end else begin
                fmt_code_next = 16'd0;
                chans_next    = 16'd0;
                rate_next     = 32'd0;
                bits_next     = 16'd0;
                skip_next     = {1'b0, csize} - 33'd16 + {32'd0, csize[0]};
                phase_next    = PH_FMT;
              end
            end else if (win_tmp[31:0] == wssd_pkg::TAG_DATA_LE && fmt_seen) begin
              if (chk != wssd_pkg::ST_OK) begin
                err_next   = chk;
                phase_next = PH_DONE;
              end else begin
                dleft_next  = csize;
                gather_next = 64'd0;
                ci_next     = 16'd0;
                phase_next  = PH_DATA;
              end
            end else begin
              skip_next = {1'b0, csize} + {32'd0, csize[0]};
              if (skip_next == 33'd0) begin
                phase_next = PH_CHUNK;
                win_next   = 64'd0;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
        PH_FMT: begin
          case (bis)
            4'd0:  fmt_code_next[7:0]   = file_byte;
            4'd1:  fmt_code_next[15:8]  = file_byte;
            4'd2:  chans_next[7:0]      = file_byte;
            4'd3:  chans_next[15:8]     = file_byte;
            4'd4:  rate_next[7:0]       = file_byte;
            4'd5:  rate_next[15:8]      = file_byte;
            4'd6:  rate_next[23:16]     = file_byte;
            4'd7:  rate_next[31:24]     = file_byte;
            4'd14: bits_next[7:0]       = file_byte;
            4'd15: bits_next[15:8]      = file_byte;
            default: ;
          endcase
          bis_next = bis_inc;
          if (bis == 4'd15) begin
            fmt_seen_next = 1'b1;
            bis_next      = 4'd0;
            if (skip == 33'd0) begin
              phase_next = PH_CHUNK;
              win_next   = 64'd0;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (skip != 33'd0) skip_next = skip - 33'd1;
          if (skip_next == 33'd0) begin
            phase_next = PH_CHUNK;
            bis_next   = 4'd0;
            win_next   = 64'd0;
          end
        end
        PH_DATA: begin
          if (dleft != 32'd0) begin
            dleft_next  = dleft - 32'd1;
            gather_next = gath_tmp;
            bis_next    = bis_inc;
            if (bis_inc >= bits[6:3]) begin
              evt_next.samp_valid = 1'b1;
              evt_next.raw        = gath_tmp;
              case (bits[6:3])
                4'd1:    evt_next.mode = wssd_pkg::MODE_U8;
                4'd2:    evt_next.mode = wssd_pkg::MODE_S16;
                4'd3:    evt_next.mode = wssd_pkg::MODE_S24;
                4'd4:    evt_next.mode = wssd_pkg::MODE_RAW32;
                default: evt_next.mode = wssd_pkg::MODE_F64;
              endcase
              if (ci == 16'd0)      evt_next.chan = wssd_pkg::CH_LEFT;
              else if (ci == 16'd1) evt_next.chan = wssd_pkg::CH_RIGHT;
              else                  evt_next.chan = wssd_pkg::CH_OTHER;
              gather_next = 64'd0;
              bis_next    = 4'd0;
              ci_next     = ci_inc[15:0];
              if (ci_inc >= {1'b0, chans}) begin
                ci_next            = 16'd0;
                evt_next.frame_end = 1'b1;
                evt_next.mono      = (chans == 16'd1);
                if (frames != {wssd_pkg::COUNT_BITS{1'b1}}) frames_next = frames + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase

      if (end_of_file) begin
        evt_next.report_valid = 1'b1;
        if (pos_next < wssd_pkg::MIN_FILE_BYTES) evt_next.status = wssd_pkg::ST_SHORT;
        else if (err_next != wssd_pkg::ST_OK)    evt_next.status = err_next;
        else if (phase_next == PH_DATA)          evt_next.status = wssd_pkg::ST_OK;
        else                                     evt_next.status = wssd_pkg::ST_NO_DATA;
        evt_next.rate     = rate_next;
        evt_next.channels = chans_next;
        evt_next.frames   = frames_next;
        // back to the post-reset state for the next file
        phase_next    = PH_HEADER;
        pos_next      = 6'd0;
        win_next      = 64'd0;
        skip_next     = 33'd0;
        dleft_next    = 32'd0;
        fmt_code_next = 16'd0;
        chans_next    = 16'd0;
        rate_next     = 32'd0;
        bits_next     = 16'd0;
        fmt_seen_next = 1'b0;
        gather_next   = 64'd0;
        bis_next      = 4'd0;
        ci_next       = 16'd0;
        frames_next   = '0;
        err_next      = wssd_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      pos      <= 6'd0;
      win      <= 64'd0;
      skip     <= 33'd0;
      dleft    <= 32'd0;
      fmt_code <= 16'd0;
      chans    <= 16'd0;
      rate     <= 32'd0;
      bits     <= 16'd0;
      fmt_seen <= 1'b0;
      gather   <= 64'd0;
      bis      <= 4'd0;
      ci       <= 16'd0;
      frames   <= '0;
      err      <= wssd_pkg::ST_OK;
      evt      <= '0;
    end else begin
      phase    <= phase_next;
      pos      <= pos_next;
      win      <= win_next;
      skip     <= skip_next;
      dleft    <= dleft_next;
      fmt_code <= fmt_code_next;
      chans    <= chans_next;
      rate     <= rate_next;
      bits     <= bits_next;
      fmt_seen <= fmt_seen_next;
      gather   <= gather_next;
      bis      <= bis_next;
      ci       <= ci_next;
      frames   <= frames_next;
      err      <= err_next;
      evt      <= evt_next;
    end
  end

endmodule

// File: hw/rtl/wssd_convert.sv
`timescale 1ns / 1ps
// sample conversion to single precision and stereo frame assembly
// depends on wssd_pkg
module wssd_convert (
  input  logic                clk,
  input  logic                rst,
  input  wssd_pkg::samp_evt_t evt,
  output logic                push0,
  output wssd_pkg::result_t   push0_data,
  output logic                push1,
  output wssd_pkg::result_t   push1_data
);

  logic [31:0]       held_left, held_left_next;
  logic [31:0]       held_right, held_right_next;
  logic [31:0]       val;
  wssd_pkg::result_t frame_res;
  wssd_pkg::result_t report_res;
  logic              frame_out;

  always_comb begin
    case (evt.mode)
      wssd_pkg::MODE_U8:
        val = wssd_pkg::pcm_to_single({{16{~evt.raw[7]}}, ~evt.raw[7], evt.raw[6:0]}, 5'd7);
      wssd_pkg::MODE_S16:
        val = wssd_pkg::pcm_to_single({{8{evt.raw[15]}}, evt.raw[15:0]}, 5'd15);
      wssd_pkg::MODE_S24:
        val = wssd_pkg::pcm_to_single(evt.raw[23:0], 5'd23);
      wssd_pkg::MODE_RAW32:
        val = evt.raw[31:0];
      default:
        val = wssd_pkg::double_to_single(evt.raw);
    endcase

    held_left_next  = held_left;
    held_right_next = held_right;
    if (evt.samp_valid && evt.chan == wssd_pkg::CH_LEFT)  held_left_next  = val;
    if (evt.samp_valid && evt.chan == wssd_pkg::CH_RIGHT) held_right_next = val;

    frame_out          = evt.samp_valid && evt.frame_end;
    frame_res          = '0;
    frame_res.kind     = wssd_pkg::RK_FRAME;
    frame_res.left     = held_left_next;
    frame_res.right    = evt.mono ? held_left_next : held_right_next;

    report_res          = '0;
    report_res.kind     = wssd_pkg::RK_REPORT;
    report_res.status   = evt.status;
    report_res.rate     = evt.rate;
    report_res.channels = evt.channels;
    report_res.frames   = 32'(evt.frames);

    push0      = frame_out || evt.report_valid;
    push0_data = frame_out ? frame_res : report_res;
    push1      = frame_out && evt.report_valid;
    push1_data = report_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left  <= 32'd0;
      held_right <= 32'd0;
    end else begin
      held_left  <= held_left_next;
      held_right <= held_right_next;
    end
  end

endmodule

// File: hw/rtl/wssd_fifo.sv
`timescale 1ns / 1ps
// result queue: up to two writes and one read per cycle
// depends on wssd_pkg
module wssd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push0,
  input  wssd_pkg::result_t push0_data,
  input  logic              push1,
  input  wssd_pkg::result_t push1_data,
  input  logic              pop,
  output logic              not_empty,
  output wssd_pkg::result_t head_data,
  output logic              room
);

  wssd_pkg::result_t              mem [wssd_pkg::FIFO_DEPTH];
  logic [wssd_pkg::FIFO_AW-1:0]   head, tail;
  logic [wssd_pkg::FIFO_AW:0]     count, count_next;
  logic [wssd_pkg::FIFO_AW-1:0]   tail1;

  assign tail1      = tail + 1'b1;
  assign not_empty  = (count != '0);
  assign head_data  = mem[head];
  assign room       = (count <= (wssd_pkg::FIFO_AW+1)'(wssd_pkg::FIFO_LIMIT));
  assign count_next = count + (wssd_pkg::FIFO_AW+1)'(push0) + (wssd_pkg::FIFO_AW+1)'(push1)
                      - (wssd_pkg::FIFO_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push0) mem[tail] <= push0_data;
    if (push1) mem[tail1] <= push1_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) head <= head + 1'b1;
      tail  <= tail + (wssd_pkg::FIFO_AW)'(push0) + (wssd_pkg::FIFO_AW)'(push1);
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (wssd_pkg::FIFO_AW+1)'(wssd_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_pair_order: assert property (@(posedge clk) disable iff (rst) push1 |-> push0)
    else $error("second write without first");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("read from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !push0 && !pop |=> count == $past(count))
    else $error("queue count moved without access");

endmodule

// File: hw/rtl/wav_stream_sample_decoder_core.sv
`timescale 1ns / 1ps
// top level of the wav stream decoder: parser, converter and result queue
// depends on wssd_pkg, wssd_parser, wssd_convert, wssd_fifo
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid, in_stall | file_byte, end_of_file
//   out     | out_valid, out_stall | result_kind, left_sample, right_sample, status,
//           |                    | rate_hz, channel_count, frame_count
//
// one byte request per cycle while in_stall is low; each byte goes to the queue
// head through the parser register, then conversion into the result queue
// the byte carrying end_of_file may give a frame and a report, pushed together
// in_stall rises while the eight-entry result queue holds more than four results
// rst is synchronous and returns the parser to the header phase with empty queue
module wav_stream_sample_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [31:0] left_sample,
  output logic [31:0] right_sample,
  output logic [2:0]  status,
  output logic [31:0] rate_hz,
  output logic [15:0] channel_count,
  output logic [31:0] frame_count
);

  // accepted byte request and completed result request
  logic                acc;
  logic                pop;
  logic                room;
  wssd_pkg::samp_evt_t evt;
  logic                push0, push1;
  wssd_pkg::result_t   push0_data, push1_data;
  wssd_pkg::result_t   head_data;

  assign in_stall = !room;
  assign acc      = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  // byte parser with all file state, registered event out
  wssd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .evt         (evt)
  );

  // float conversion and left/right holding
  wssd_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .push0      (push0),
    .push0_data (push0_data),
    .push1      (push1),
    .push1_data (push1_data)
  );

  // output queue decouples the stall of the consumer from the parser
  wssd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (push0),
    .push0_data (push0_data),
    .push1      (push1),
    .push1_data (push1_data),
    .pop        (pop),
    .not_empty  (out_valid),
    .head_data  (head_data),
    .room       (room)
  );

  assign result_kind   = head_data.kind;
  assign left_sample   = head_data.left;
  assign right_sample  = head_data.right;
  assign status        = head_data.status;
  assign rate_hz       = head_data.rate;
  assign channel_count = head_data.channels;
  assign frame_count   = head_data.frames;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for wav_stream_sample_decoder_core: builds wav files as byte
// requests, predicts every frame and report, and checks them under random idling
// depends on wssd_pkg and the decoder rtl
module tb;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] left;
    logic [31:0] right;
    logic [2:0]  st;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [31:0] frames;
  } outcome_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  file_byte;
  logic        end_of_file;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [31:0] left_sample;
  logic [31:0] right_sample;
  logic [2:0]  status;
  logic [31:0] rate_hz;
  logic [15:0] channel_count;
  logic [31:0] frame_count;

  wav_stream_sample_decoder_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .file_byte(file_byte), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .left_sample(left_sample), .right_sample(right_sample),
    .status(status), .rate_hz(rate_hz), .channel_count(channel_count),
    .frame_count(frame_count)
  );

  byte_req_t byte_queue[$];
  outcome_t  expected_results[$];
  byte_req_t file_buf[$];
  int        errors = 0;
  int        cycles = 0;
  logic      took;

  // predictor state
  phase_t      ph;
  logic [32:0] pos_cnt;
  logic [63:0] win;
  logic [32:0] skip_left;
  logic [31:0] data_left;
  logic [15:0] fmt_code;
  logic [15:0] chans_l;
  logic [31:0] rate_l;
  logic [15:0] bits_l;
  logic        fmt_seen;
  logic [63:0] gather;
  logic [3:0]  bis;
  logic [15:0] chan_idx;
  logic [31:0] held_l;
  logic [31:0] held_r;
  logic [31:0] frames_done;
  logic [2:0]  err_code;

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_parser();
    ph = PH_HEADER; pos_cnt = '0; win = '0; skip_left = '0; data_left = '0;
    fmt_code = '0; chans_l = '0; rate_l = '0; bits_l = '0; fmt_seen = 1'b0;
    gather = '0; bis = '0; chan_idx = '0; held_l = '0; held_r = '0;
    frames_done = '0; err_code = '0;
  endfunction

  // integer v times 2^-frac as single bits, always exact here
  function automatic logic [31:0] scaled_pcm(input int v, input int frac);
    logic [31:0] mag;
    int          msb;
    logic [31:0] mant;
    msb = 0;
    if (v == 0) return 32'd0;
    mag = (v < 0) ? -v : v;
    for (int i = 0; i < 32; i++) if (mag[i]) msb = i;
    mant = (mag << (23 - msb)) & 32'h007F_FFFF;
    return {v < 0, 8'(127 + msb - frac), mant[22:0]};
  endfunction

  // ieee double bits to single bits, ties to even
  function automatic logic [31:0] narrow_double(input logic [63:0] d);
    logic [31:0] sgn;
    logic [10:0] ex;
    logic [51:0] man;
    logic [63:0] m;
    int          fe;
    int          sh;
    logic [31:0] base;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    sgn = {d[63], 31'd0};
    ex = d[62:52];
    man = d[51:0];
    if (ex == 11'h7FF) begin
      if (man == 0) return sgn | 32'h7F80_0000;
      return sgn | 32'h7FC0_0000 | {9'd0, man[51:29]};
    end
    m = (ex != 0) ? {11'd1, man} : {12'd0, man};
    fe = ((ex != 0) ? int'(ex) : 1) - 896;
    if (fe >= 255) return sgn | 32'h7F80_0000;
    if (fe <= 0) begin
      sh = 30 - fe;
      base = 0;
    end else begin
      sh = 29;
      base = 32'(fe - 1) << 23;
    end
    if (sh > 63) return sgn;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return sgn | (base + q[31:0]);
  endfunction

  function automatic logic [31:0] convert_sample(input logic [63:0] g);
    case (bits_l)
      16'd64: return narrow_double(g);
      16'd32: return g[31:0];
      16'd8:  return scaled_pcm(int'(g[7:0]) - 128, 7);
      16'd16: return scaled_pcm(int'($signed(g[15:0])), 15);
      default: return scaled_pcm(int'($signed(g[23:0])), 23);
    endcase
  endfunction

  function automatic logic [2:0] format_verdict();
    if (fmt_code != wssd_pkg::FMT_PCM && fmt_code != wssd_pkg::FMT_FLOAT)
      return wssd_pkg::ST_UNSUPP;
    if (chans_l == 0 || bits_l < 8) return wssd_pkg::ST_MALFORMED;
    if (fmt_code == wssd_pkg::FMT_PCM && !(bits_l inside {16'd8, 16'd16, 16'd24, 16'd32}))
      return wssd_pkg::ST_UNSUPP;
    if (fmt_code == wssd_pkg::FMT_FLOAT && !(bits_l inside {16'd32, 16'd64}))
      return wssd_pkg::ST_UNSUPP;
    return wssd_pkg::ST_OK;
  endfunction

  function automatic void enter_chunk();
    ph = PH_CHUNK; bis = 0; win = 0;
  endfunction

  function automatic void chunk_header_seen();
    logic [31:0] id;
    logic [31:0] sz;
    logic [2:0]  verdict;
    id = win[31:0];
    sz = win[63:32];
    bis = 0;
    if (id == wssd_pkg::TAG_FMT_LE) begin
      if (sz < 16) begin
        err_code = wssd_pkg::ST_MALFORMED; ph = PH_DONE;
      end else begin
        fmt_code = 0; chans_l = 0; rate_l = 0; bits_l = 0;
        skip_left = 33'(sz) - 16 + sz[0];
        ph = PH_FMT;
      end
    end else if (id == wssd_pkg::TAG_DATA_LE && fmt_seen) begin
      verdict = format_verdict();
      if (verdict != wssd_pkg::ST_OK) begin
        err_code = verdict; ph = PH_DONE;
      end else begin
        data_left = sz; gather = 0; chan_idx = 0; ph = PH_DATA;
      end
    end else begin
      skip_left = 33'(sz) + sz[0];
      if (skip_left == 0) enter_chunk();
      else ph = PH_SKIP;
    end
  endfunction

  // advance the predicted parser by one accepted byte, queueing what it yields
  function automatic void decode_byte(input logic [7:0] b, input logic eof);
    logic [32:0] here;
    logic [3:0]  off;
    logic [31:0] val;
    outcome_t    o;
    here = pos_cnt;
    if (pos_cnt != 33'h1_FFFF_FFFF) pos_cnt = pos_cnt + 1;
    case (ph)
      PH_HEADER: begin
        win = {win[55:0], b};
        if (here == 3 && win[31:0] != wssd_pkg::TAG_RIFF_BE) begin
          err_code = wssd_pkg::ST_BAD_HDR; ph = PH_DONE;
        end else if (here == 11) begin
          if (win[31:0] != wssd_pkg::TAG_WAVE_BE) begin
            err_code = wssd_pkg::ST_BAD_HDR; ph = PH_DONE;
          end else enter_chunk();
        end
      end
      PH_CHUNK: begin
        win[8*bis[2:0] +: 8] = b;
        bis = bis + 1;
        if (bis >= 8) chunk_header_seen();
      end
      PH_FMT: begin
        off = bis;
        if (off < 2) fmt_code[8*off[0] +: 8] = b;
        else if (off < 4) chans_l[8*off[0] +: 8] = b;
        else if (off < 8) rate_l[8*off[1:0] +: 8] = b;
        else if (off >= 14) bits_l[8*off[0] +: 8] = b;
        bis = off + 1;
        if (off == 15) begin
          fmt_seen = 1; bis = 0;
          if (skip_left == 0) enter_chunk();
          else ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_left > 0) skip_left = skip_left - 1;
        if (skip_left == 0) enter_chunk();
      end
      PH_DATA: begin
        if (data_left != 0) begin
          data_left = data_left - 1;
          gather[8*bis[2:0] +: 8] = b;
          bis = bis + 1;
          if (bis >= bits_l / 8) begin
            val = convert_sample(gather);
            gather = 0; bis = 0;
            if (chan_idx == 0) held_l = val;
            else if (chan_idx == 1) held_r = val;
            chan_idx = chan_idx + 1;
            if (chan_idx >= chans_l) begin
              chan_idx = 0;
              o = '0;
              o.kind = wssd_pkg::RK_FRAME;
              o.left = held_l;
              o.right = (chans_l == 1) ? held_l : held_r;
              expected_results.push_back(o);
              if (frames_done != 32'hFFFF_FFFF) frames_done = frames_done + 1;
            end
          end
        end
      end
      default: ;
    endcase
    if (eof) begin
      o = '0;
      o.kind = wssd_pkg::RK_REPORT;
      if (pos_cnt < 44) o.st = wssd_pkg::ST_SHORT;
      else if (err_code != 0) o.st = err_code;
      else if (ph == PH_DATA) o.st = wssd_pkg::ST_OK;
      else o.st = wssd_pkg::ST_NO_DATA;
      o.rate = rate_l;
      o.chans = chans_l;
      o.frames = frames_done;
      expected_results.push_back(o);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------- file building

  function automatic void put8(input logic [7:0] v);
    byte_req_t r;
    r.data = v;
    r.last = 1'b0;
    file_buf.push_back(r);
  endfunction

  function automatic void put16(input logic [15:0] v);
    put8(v[7:0]); put8(v[15:8]);
  endfunction

  function automatic void put32(input logic [31:0] v);
    put16(v[15:0]); put16(v[31:16]);
  endfunction

  // tags go out in text order
  function automatic void put_tag(input logic [31:0] be);
    put8(be[31:24]); put8(be[23:16]); put8(be[15:8]); put8(be[7:0]);
  endfunction

  // sample value, often one of the corner values of its width
  function automatic logic [63:0] pick_sample(input int nbits, input logic [15:0] code);
    logic [63:0] r;
    logic [10:0] ex;
    r = {$urandom, $urandom};
    if (nbits == 64 && code == wssd_pkg::FMT_FLOAT) begin
      case ($urandom_range(0, 9))
        0: ex = 11'h7FF;
        1: ex = 11'h000;
        2: ex = 11'(896 - $urandom_range(0, 30));
        3: ex = 11'(896 + 254 + $urandom_range(0, 3));
        4: ex = 11'h000 + 11'($urandom_range(1, 900));
        5: ex = 11'($urandom_range(0, 2047));
        default: ex = 11'($urandom_range(1000, 1100));
      endcase
      r[62:52] = ex;
      case ($urandom_range(0, 7))
        0: r[51:0] = 0;
        1: r[28:0] = 29'h1000_0000;
        2: r[28:0] = 29'h1000_0000 | 29'($urandom_range(0, 1));
        default: ;
      endcase
    end else if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: r = 64'd0;
        1: r = '1;
        2: r = 64'd1 << (nbits - 1);
        3: r = (64'd1 << (nbits - 1)) - 1;
        default: r = 64'd1 << ((nbits == 8) ? 7 : 0);
      endcase
    end
    return r;
  endfunction

  // push the built file as requests, end_of_file on its last byte
  function automatic void emit_file(input int cut);
    int n;
    n = file_buf.size();
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) begin
      byte_req_t r;
      r = file_buf[i];
      r.last = (i == n - 1);
      byte_queue.push_back(r);
    end
    file_buf.delete();
  endfunction

  // flags: 0 bad riff, 1 bad wave, 2 junk chunk first, 3 data chunk before fmt,
  // 4 no data chunk
  function automatic void build_wav(input logic [15:0] code, input logic [15:0] chans,
                                    input logic [15:0] nbits, input int fmt_len,
                                    input int frames, input int partial, input int trail,
                                    input logic [4:0] flags, input int cut);
    int          sbytes;
    int          dsize;
    logic [63:0] s;
    sbytes = (nbits >= 8) ? nbits / 8 : 1;
    put_tag(flags[0] ? 32'h5249_4647 : wssd_pkg::TAG_RIFF_BE);
    put32($urandom);
    put_tag(flags[1] ? 32'h5741_5646 : wssd_pkg::TAG_WAVE_BE);
    if (flags[2]) begin
      dsize = $urandom_range(0, 5);
      put_tag(32'h4C49_5354);
      put32(dsize);
      for (int i = 0; i < dsize + (dsize % 2); i++) put8(8'($urandom));
    end
    if (flags[3]) begin
      put32(wssd_pkg::TAG_DATA_LE); put32(3);
      repeat (4) put8(8'($urandom));
    end
    put32(wssd_pkg::TAG_FMT_LE);
    put32(fmt_len);
    if (fmt_len < 16) begin
      for (int i = 0; i < fmt_len; i++) put8(8'($urandom));
    end else begin
      put16(code); put16(chans); put32($urandom_range(8000, 192000) | ($urandom << 24));
      put32($urandom); put16(16'(chans * sbytes)); put16(nbits);
      for (int i = 16; i < fmt_len + (fmt_len % 2); i++) put8(8'($urandom));
    end
    if (!flags[4]) begin
      dsize = frames * chans * sbytes + partial;
      put32(wssd_pkg::TAG_DATA_LE); put32(dsize);
      for (int f = 0; f < frames * chans; f++) begin
        s = pick_sample(sbytes * 8, code);
        for (int k = 0; k < sbytes; k++) put8(s[8*k +: 8]);
      end
      for (int i = 0; i < partial; i++) put8(8'($urandom));
    end
    for (int i = 0; i < trail; i++) put8(8'($urandom));
    emit_file(cut);
  endfunction

  function automatic void build_random_wav();
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] nbits;
    logic [4:0]  flags;
    int          fmt_len;
    int          cut;
    int          pick;
    pick = $urandom_range(0, 19);
    code = wssd_pkg::FMT_PCM;
    case ($urandom_range(0, 5))
      0: nbits = 16'd8;
      1: nbits = 16'd16;
      2: nbits = 16'd24;
      3: nbits = 16'd32;
      4: begin code = wssd_pkg::FMT_FLOAT; nbits = 16'd32; end
      default: begin code = wssd_pkg::FMT_FLOAT; nbits = 16'd64; end
    endcase
    chans = 16'($urandom_range(1, 3));
    fmt_len = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 21) : 16;
    flags = 0;
    flags[2] = ($urandom_range(0, 3) == 0);
    flags[3] = ($urandom_range(0, 7) == 0);
    cut = 0;
    // a minority of broken files
    case (pick)
      0: flags[$urandom_range(0, 1)] = 1;
      1: cut = $urandom_range(1, 60);
      2: fmt_len = $urandom_range(0, 15);
      3: code = 16'($urandom);
      4: chans = 16'd0;
      5: nbits = 16'($urandom_range(0, 70));
      6: flags[4] = 1;
      default: ;
    endcase
    build_wav(code, chans, nbits, fmt_len, $urandom_range(0, 6),
              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
              ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0, flags, cut);
  endfunction

  // ---------------------------------------------------------------- driver

  int  burst_left;
  int  gap_left;
  int  stall_mode;
  int  stall_age;

  // request side: bursts of requests separated by random gaps, payload held while stalled
  always @(negedge clk) begin
    byte_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
      file_byte <= 8'd0;
      end_of_file <= 1'b0;
    end else if (!in_valid || took) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        r = byte_queue.pop_front();
        in_valid <= 1'b1;
        file_byte <= r.data;
        end_of_file <= r.last;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side stall pattern, changes character every so often
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_age = stall_age + 1;
      if (stall_age >= 80) begin
        stall_age = 0;
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ((cycles % 7) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t e;
    cycles <= cycles + 1;
    if (rst) begin
      took <= 1'b0;
    end else begin
      took <= in_valid && !in_stall;
      if (in_valid && !in_stall) decode_byte(file_byte, end_of_file);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result, kind %b", result_kind);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("result_kind", 32'(e.kind), 32'(result_kind));
          check_field("left_sample", e.left, left_sample);
          check_field("right_sample", e.right, right_sample);
          check_field("status", 32'(e.st), 32'(status));
          check_field("rate_hz", e.rate, rate_hz);
          check_field("channel_count", 32'(e.chans), 32'(channel_count));
          check_field("frame_count", e.frames, frame_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("wav_stream_sample_decoder_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_parser();
    burst_left = 10;
    gap_left = 0;
    stall_mode = 0;
    stall_age = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    file_byte = 8'd0;
    end_of_file = 1'b0;
    out_stall = 1'b0;
    took = 1'b0;

    // directed files: each format, corner samples, and every failure path
    build_wav(wssd_pkg::FMT_PCM, 2, 8, 16, 4, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_PCM, 1, 16, 18, 4, 1, 3, 5'b00100, 0);
    build_wav(wssd_pkg::FMT_PCM, 3, 24, 17, 3, 2, 0, 5'b01000, 0);
    build_wav(wssd_pkg::FMT_PCM, 2, 32, 16, 2, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_FLOAT, 1, 32, 16, 3, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_FLOAT, 2, 64, 16, 6, 3, 2, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_PCM, 2, 16, 16, 2, 0, 0, 5'b00000, 30);
    build_wav(wssd_pkg::FMT_PCM, 2, 16, 16, 2, 0, 0, 5'b00001, 0);
    build_wav(wssd_pkg::FMT_PCM, 2, 16, 16, 2, 0, 0, 5'b00010, 0);
    build_wav(wssd_pkg::FMT_PCM, 2, 16, 12, 2, 0, 0, 5'b00000, 0);
    build_wav(16'd2, 2, 4, 16, 2, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_PCM, 2, 12, 16, 2, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_FLOAT, 2, 16, 16, 2, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_PCM, 0, 16, 16, 2, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_FLOAT, 1, 4, 16, 2, 0, 0, 5'b00000, 0);
    build_wav(wssd_pkg::FMT_PCM, 1, 8, 16, 2, 0, 12, 5'b10000, 0);

    // random files until the byte budget is spent
    while (byte_queue.size() < 1300) build_random_wav();

    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while (byte_queue.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("wav_stream_sample_decoder_core test passed");
    else
      $display("wav_stream_sample_decoder_core test failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/wssd_pkg.sv
hw/rtl/wssd_parser.sv
hw/rtl/wssd_convert.sv
hw/rtl/wssd_fifo.sv
hw/rtl/wav_stream_sample_decoder_core.sv
tb/tb.sv
